### rtl/core/mcpr_pkg.sv
// Shared types, constants and helpers for the modified clock replacement unit.
package mcpr_pkg;

    localparam int WS_SLOTS  = 16;
    localparam int SLOT_W    = 4;
    localparam int LIM_W     = 5;
    localparam int PAGE_BITS = 20;

    // Commands from the controller to the datapath.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LATCH     = 4'd1;
    localparam logic [3:0] OP_LK_START  = 4'd2;
    localparam logic [3:0] OP_LK_NEXT   = 4'd3;
    localparam logic [3:0] OP_HIT       = 4'd4;
    localparam logic [3:0] OP_MISS      = 4'd5;
    localparam logic [3:0] OP_FILL      = 4'd6;
    localparam logic [3:0] OP_SRCH_INIT = 4'd7;
    localparam logic [3:0] OP_SRCH_STEP = 4'd8;
    localparam logic [3:0] OP_EVICT     = 4'd9;
    localparam logic [3:0] OP_PUBLISH   = 4'd10;

    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_FAULT  = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [PAGE_BITS-1:0] page;
        logic                 is_write;
    } in_item_t;

    typedef struct packed {
        logic                 hit;
        logic                 evicted;
        logic [PAGE_BITS-1:0] victim_page;
        logic                 victim_dirty;
        logic [SLOT_W-1:0]    slot;
    } out_item_t;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic free_found;
        logic lk_match;
        logic lk_last;
        logic srch_found;
        logic srch_pass_end;
        logic srch_pass_last;
        logic out_free;
    } stat_t;

    // Slot after the given one, wrapping at the working set limit.
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [LIM_W-1:0]  lim);
        logic [LIM_W-1:0] inc;
        inc = {1'b0, s} + LIM_W'(1);
        return (inc >= lim) ? '0 : inc[SLOT_W-1:0];
    endfunction

endpackage

### rtl/core/mcpr_dp.sv
// Datapath: tag memory, slot marks, clock hand, search counters and result registers.
module mcpr_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcpr_pkg::cmd_t                cmd,
    output mcpr_pkg::stat_t               stat,
    input  mcpr_pkg::in_item_t            in_data,
    input  logic                          cfg_we,
    input  logic [mcpr_pkg::LIM_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mcpr_pkg::out_item_t           out_data
);

    logic [mcpr_pkg::LIM_W-1:0]     ws_limit_reg;
    logic [mcpr_pkg::WS_SLOTS-1:0]  valid_reg;
    logic [mcpr_pkg::WS_SLOTS-1:0]  used_reg;
    logic [mcpr_pkg::WS_SLOTS-1:0]  dirty_reg;
    logic [mcpr_pkg::SLOT_W-1:0]    hand_reg;
    logic [mcpr_pkg::SLOT_W-1:0]    idx_reg;
    logic [mcpr_pkg::SLOT_W-1:0]    start_reg;
    logic [mcpr_pkg::SLOT_W-1:0]    cnt_reg;
    logic [1:0]                     pass_reg;
    logic                           out_valid_reg;
    mcpr_pkg::in_item_t             item_reg;
    mcpr_pkg::out_item_t            res_reg;
    mcpr_pkg::out_item_t            out_reg;

    logic [mcpr_pkg::PAGE_BITS-1:0] tag_mem [mcpr_pkg::WS_SLOTS];
    logic [mcpr_pkg::PAGE_BITS-1:0] rdata_reg;
    logic                           tag_we;
    logic [mcpr_pkg::SLOT_W-1:0]    tag_waddr;

    logic [mcpr_pkg::LIM_W-1:0]     lim;
    logic [mcpr_pkg::SLOT_W-1:0]    free_idx;
    logic                           free_found;
    logic [mcpr_pkg::SLOT_W-1:0]    start;
    logic                           srch_found;
    logic                           pass_end;

    always_comb
    begin
        if (ws_limit_reg == '0)
            lim = mcpr_pkg::LIM_W'(1);
        else if (ws_limit_reg > mcpr_pkg::LIM_W'(mcpr_pkg::WS_SLOTS))
            lim = mcpr_pkg::LIM_W'(mcpr_pkg::WS_SLOTS);
        else
            lim = ws_limit_reg;
    end

    // Lowest empty slot inside the working set.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < mcpr_pkg::WS_SLOTS; i++)
        begin
            if (!free_found && (mcpr_pkg::LIM_W'(i) < lim) && !valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = mcpr_pkg::SLOT_W'(i);
            end
        end
    end

    assign start      = ({1'b0, hand_reg} < lim) ? hand_reg : '0;
    // Pass one wants neither mark set; pass two only needs the used mark clear.
    assign srch_found = pass_reg[0] ? !used_reg[idx_reg]
                                    : (!used_reg[idx_reg] && !dirty_reg[idx_reg]);
    assign pass_end   = ({1'b0, cnt_reg} == (lim - mcpr_pkg::LIM_W'(1)));

    assign stat.func           = item_reg.func;
    assign stat.free_found     = free_found;
    assign stat.lk_match       = valid_reg[idx_reg] && (rdata_reg == item_reg.page);
    assign stat.lk_last        = (({1'b0, idx_reg} + mcpr_pkg::LIM_W'(1)) >= lim);
    assign stat.srch_found     = srch_found;
    assign stat.srch_pass_end  = pass_end;
    assign stat.srch_pass_last = (pass_reg == 2'd3);
    assign stat.out_free       = !out_valid_reg || !out_stall;

    assign tag_we    = (cmd.op == mcpr_pkg::OP_FILL) || (cmd.op == mcpr_pkg::OP_EVICT);
    assign tag_waddr = (cmd.op == mcpr_pkg::OP_FILL) ? free_idx : idx_reg;

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[tag_waddr] <= item_reg.page;
        rdata_reg <= tag_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            mcpr_pkg::OP_LATCH:
                item_reg <= in_data;
            mcpr_pkg::OP_HIT:
                res_reg <= '{hit: 1'b1, slot: idx_reg, default: '0};
            mcpr_pkg::OP_MISS:
                res_reg <= '0;
            mcpr_pkg::OP_FILL:
                res_reg <= '{slot: free_idx, default: '0};
            mcpr_pkg::OP_EVICT:
                res_reg <= '{hit:          1'b0,
                             evicted:      1'b1,
                             victim_page:  rdata_reg,
                             victim_dirty: dirty_reg[idx_reg],
                             slot:         idx_reg};
            mcpr_pkg::OP_PUBLISH:
                out_reg <= res_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_limit_reg  <= mcpr_pkg::LIM_W'(mcpr_pkg::WS_SLOTS);
            valid_reg     <= '0;
            used_reg      <= '0;
            dirty_reg     <= '0;
            hand_reg      <= '0;
            idx_reg       <= '0;
            start_reg     <= '0;
            cnt_reg       <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ws_limit_reg <= cfg_data;

            if (cmd.op == mcpr_pkg::OP_PUBLISH)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (cmd.op)
                mcpr_pkg::OP_LK_START:
                    idx_reg <= '0;
                mcpr_pkg::OP_LK_NEXT:
                    idx_reg <= idx_reg + mcpr_pkg::SLOT_W'(1);
                mcpr_pkg::OP_HIT:
                begin
                    used_reg[idx_reg] <= 1'b1;
                    if (item_reg.is_write)
                        dirty_reg[idx_reg] <= 1'b1;
                end
                mcpr_pkg::OP_FILL:
                begin
                    valid_reg[free_idx] <= 1'b1;
                    used_reg[free_idx]  <= 1'b0;
                    dirty_reg[free_idx] <= 1'b0;
                    hand_reg            <= mcpr_pkg::next_slot(free_idx, lim);
                end
                mcpr_pkg::OP_SRCH_INIT:
                begin
                    idx_reg   <= start;
                    start_reg <= start;
                    cnt_reg   <= '0;
                    pass_reg  <= '0;
                end
                mcpr_pkg::OP_SRCH_STEP:
                begin
                    if (pass_reg[0] && used_reg[idx_reg])
                        used_reg[idx_reg] <= 1'b0;
                    if (!srch_found)
                    begin
                        if (pass_end)
                        begin
                            // A failed pass restarts at the start slot; a failed final pass leaves it as victim.
                            idx_reg  <= start_reg;
                            cnt_reg  <= '0;
                            pass_reg <= pass_reg + 2'd1;
                        end
                        else
                        begin
                            idx_reg <= mcpr_pkg::next_slot(idx_reg, lim);
                            cnt_reg <= cnt_reg + mcpr_pkg::SLOT_W'(1);
                        end
                    end
                end
                mcpr_pkg::OP_EVICT:
                begin
                    valid_reg[idx_reg] <= 1'b1;
                    used_reg[idx_reg]  <= 1'b0;
                    dirty_reg[idx_reg] <= 1'b0;
                    hand_reg           <= mcpr_pkg::next_slot(idx_reg, lim);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/core/mcpr_ctrl.sv
// Controller state machine that sequences lookups, fills and the clock search.
module mcpr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  mcpr_pkg::stat_t stat,
    output mcpr_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_LK_RD    = 3'd2;
    localparam logic [2:0] ST_LK_CMP   = 3'd3;
    localparam logic [2:0] ST_SEARCH   = 3'd4;
    localparam logic [2:0] ST_V_RD     = 3'd5;
    localparam logic [2:0] ST_V_WR     = 3'd6;
    localparam logic [2:0] ST_FINISH   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = mcpr_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = mcpr_pkg::OP_LATCH;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.func == mcpr_pkg::FUNC_ACCESS)
                begin
                    cmd.op     = mcpr_pkg::OP_LK_START;
                    state_next = ST_LK_RD;
                end
                else if (stat.free_found)
                begin
                    cmd.op     = mcpr_pkg::OP_FILL;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.op     = mcpr_pkg::OP_SRCH_INIT;
                    state_next = ST_SEARCH;
                end
            end
            ST_LK_RD:
                state_next = ST_LK_CMP;
            ST_LK_CMP:
            begin
                priority if (stat.lk_match)
                begin
                    cmd.op     = mcpr_pkg::OP_HIT;
                    state_next = ST_FINISH;
                end
                else if (stat.lk_last)
                begin
                    cmd.op     = mcpr_pkg::OP_MISS;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.op     = mcpr_pkg::OP_LK_NEXT;
                    state_next = ST_LK_RD;
                end
            end
            ST_SEARCH:
            begin
                cmd.op = mcpr_pkg::OP_SRCH_STEP;
                if (stat.srch_found || (stat.srch_pass_end && stat.srch_pass_last))
                    state_next = ST_V_RD;
            end
            ST_V_RD:
                state_next = ST_V_WR;
            ST_V_WR:
            begin
                cmd.op     = mcpr_pkg::OP_EVICT;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = mcpr_pkg::OP_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/modified_clock_page_replacement_unit.sv
// Top level of the modified clock (enhanced second chance) page replacement unit.
//
// The unit takes one request at a time and returns one result for it. An access
// compares the working set tags one slot at a time through the single tag memory
// read port, reading each slot in LK_RD and comparing it in LK_CMP. A fault with
// an empty slot fills the lowest empty slot without a search. A fault on a full set
// runs the clock search at one slot per cycle, at most three full passes over the
// limit and the first slot of a fourth, then reads the victim tag. A stalled output
// holds a finished request until the previous result is taken. A finished result
// waits in an output register while the next request is already accepted. The user
// must write ws_limit only while the unit is idle; the unit itself does not enforce
// it. A limit written while idle takes effect for the next request.
module modified_clock_page_replacement_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mcpr_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mcpr_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mcpr_pkg::LIM_W-1:0]    cfg_data
);

    mcpr_pkg::cmd_t  cmd;
    mcpr_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    mcpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcpr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // An accepted request keeps the unit busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("unit not busy after accepting a request");

    // A new result appears only at the end of work on a request.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in progress");

    a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.hit && out_data.evicted))
        else $error("result is both hit and eviction");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.evicted) |->
            (out_data.victim_page == '0 && !out_data.victim_dirty))
        else $error("victim fields set without an eviction");

endmodule
